// ===== sv/ms_pkg.sv =====
// shared widths, codes and control types for the moebius sieve table
package ms_pkg;

    localparam int CFG_W          = 13;
    localparam int IDX_W          = 12;
    localparam int MU_W           = 2;
    localparam int ST_W           = 2;
    localparam int MAX_LENGTH_DEF = 4096;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_READY = 2'd2;

    localparam logic CMD_SIEVE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INIT    = 8'b0000_0010,
        S_SCAN    = 8'b0000_0100,
        S_CHECK   = 8'b0000_1000,
        S_NEG     = 8'b0001_0000,
        S_SQSTART = 8'b0010_0000,
        S_SQ      = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } ms_state_t;

    typedef struct packed {
        logic rd_load;
        logic init_start;
        logic init_step;
        logic scan_start;
        logic scan_rd;
        logic p_inc;
        logic neg_start;
        logic neg_rd;
        logic sq_start;
        logic sq_wr;
        logic finish;
    } ms_cmd_t;

    typedef struct packed {
        logic q_lt_n;
        logic p_lt_n;
        logic marked;
    } ms_stat_t;

endpackage

// ===== sv/ms_ctrl.sv =====
// sequencer for request handshake and sieve passes
module ms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             cmd,
    input  logic             out_stall,
    input  ms_pkg::ms_stat_t stat,
    output ms_pkg::ms_cmd_t  dp_cmd,
    output logic             in_stall,
    output logic             out_valid
);
    import ms_pkg::*;

    ms_state_t state_reg;
    ms_state_t state_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      accept;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_READ)
                    begin
                        dp_cmd.rd_load = 1'b1;
                    end
                    else
                    begin
                        dp_cmd.init_start = 1'b1;
                        state_next        = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                if (stat.q_lt_n)
                begin
                    dp_cmd.init_step = 1'b1;
                end
                else
                begin
                    dp_cmd.scan_start = 1'b1;
                    state_next        = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.p_lt_n)
                begin
                    dp_cmd.scan_rd = 1'b1;
                    state_next     = S_CHECK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                if (stat.marked)
                begin
                    dp_cmd.p_inc = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    dp_cmd.neg_start = 1'b1;
                    state_next       = S_NEG;
                end
            end
            S_NEG:
            begin
                if (stat.q_lt_n)
                begin
                    dp_cmd.neg_rd = 1'b1;
                end
                else
                begin
                    state_next = S_SQSTART;
                end
            end
            S_SQSTART:
            begin
                dp_cmd.sq_start = 1'b1;
                state_next      = S_SQ;
            end
            S_SQ:
            begin
                if (stat.q_lt_n)
                begin
                    dp_cmd.sq_wr = 1'b1;
                end
                else
                begin
                    dp_cmd.p_inc = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_DONE:
            begin
                dp_cmd.finish = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dp_cmd.rd_load || dp_cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/ms_dpath.sv =====
// table and mark memories, sieve pointers, length register and result registers
module ms_dpath #(
    parameter int MAX_LENGTH = ms_pkg::MAX_LENGTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ms_pkg::CFG_W-1:0]        cfg_data,
    input  logic [ms_pkg::IDX_W-1:0]        read_index,
    input  ms_pkg::ms_cmd_t                 dp_cmd,
    output ms_pkg::ms_stat_t                stat,
    output logic signed [ms_pkg::MU_W-1:0]  mu_value,
    output logic [ms_pkg::ST_W-1:0]         status
);
    import ms_pkg::*;

    localparam int AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int NW    = $clog2(MAX_LENGTH + 1);
    localparam int LEN_W = (CFG_W > NW) ? CFG_W : NW;
    localparam int SQ_W  = 2 * LEN_W;
    localparam int Q_W   = SQ_W + 1;

    logic [MU_W-1:0] mu_mem [MAX_LENGTH];
    logic            mark_mem [MAX_LENGTH];

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] cfg_ext;
    logic             table_ready_reg;
    logic [LEN_W-1:0] p_reg;
    logic [LEN_W-1:0] p_next;
    logic [Q_W-1:0]   q_reg;
    logic [Q_W-1:0]   q_next;
    logic [Q_W-1:0]   step_reg;
    logic [Q_W-1:0]   step_next;
    logic [SQ_W-1:0]  sq_reg;
    logic             pend_reg;
    logic [AW-1:0]    pend_addr_reg;
    logic [MU_W-1:0]  mu_rd_reg;
    logic             mark_rd_reg;
    logic [ST_W-1:0]  status_reg;
    logic             ok_reg;
    logic [ST_W-1:0]  rd_status;

    logic            mu_we;
    logic [AW-1:0]   mu_waddr;
    logic [MU_W-1:0] mu_wdata;
    logic            mark_we;
    logic [AW-1:0]   mark_waddr;
    logic            mark_wdata;

    assign cfg_ext  = LEN_W'(cfg_data);
    assign len_next = (cfg_ext > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : cfg_ext;

    assign stat.q_lt_n = q_reg < Q_W'(len_reg);
    assign stat.p_lt_n = p_reg < len_reg;
    assign stat.marked = mark_rd_reg;

    // read check: not-ready wins over range
    always_comb
    begin
        priority if (!table_ready_reg)
        begin
            rd_status = ST_NOT_READY;
        end
        else if (LEN_W'(read_index) >= len_reg)
        begin
            rd_status = ST_RANGE;
        end
        else
        begin
            rd_status = ST_OK;
        end
    end

    always_comb
    begin
        p_next = p_reg;
        if (dp_cmd.scan_start)
        begin
            p_next = LEN_W'(2);
        end
        else if (dp_cmd.p_inc)
        begin
            p_next = p_reg + LEN_W'(1);
        end
    end

    always_comb
    begin
        q_next    = q_reg;
        step_next = step_reg;
        priority if (dp_cmd.init_start)
        begin
            q_next = '0;
        end
        else if (dp_cmd.init_step)
        begin
            q_next = q_reg + Q_W'(1);
        end
        else if (dp_cmd.neg_start)
        begin
            q_next    = Q_W'(p_reg);
            step_next = Q_W'(p_reg);
        end
        else if (dp_cmd.sq_start)
        begin
            q_next    = Q_W'(sq_reg);
            step_next = Q_W'(sq_reg);
        end
        else if (dp_cmd.neg_rd || dp_cmd.sq_wr)
        begin
            q_next = q_reg + step_reg;
        end
        else
        begin
            q_next = q_reg;
        end
    end

    // table write port: init, negate write-back, square clear
    always_comb
    begin
        mu_we    = 1'b0;
        mu_waddr = q_reg[AW-1:0];
        mu_wdata = '0;
        priority if (dp_cmd.init_step)
        begin
            mu_we    = 1'b1;
            mu_wdata = (q_reg == '0) ? MU_W'(0) : MU_W'(1);
        end
        else if (pend_reg)
        begin
            mu_we    = 1'b1;
            mu_waddr = pend_addr_reg;
            mu_wdata = -mu_rd_reg;
        end
        else if (dp_cmd.sq_wr)
        begin
            mu_we = 1'b1;
        end
        else
        begin
            mu_we = 1'b0;
        end
    end

    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = q_reg[AW-1:0];
        mark_wdata = 1'b0;
        priority if (dp_cmd.init_step)
        begin
            mark_we = 1'b1;
        end
        else if (pend_reg && (pend_addr_reg != p_reg[AW-1:0]))
        begin
            mark_we    = 1'b1;
            mark_waddr = pend_addr_reg;
            mark_wdata = 1'b1;
        end
        else
        begin
            mark_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mu_we)
        begin
            mu_mem[mu_waddr] <= mu_wdata;
        end
        if (dp_cmd.rd_load)
        begin
            mu_rd_reg <= mu_mem[AW'(read_index)];
        end
        else if (dp_cmd.neg_rd)
        begin
            mu_rd_reg <= mu_mem[q_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (dp_cmd.scan_rd)
        begin
            mark_rd_reg <= mark_mem[p_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        q_reg         <= q_next;
        step_reg      <= step_next;
        sq_reg        <= SQ_W'(p_reg) * SQ_W'(p_reg);
        pend_addr_reg <= q_reg[AW-1:0];
        if (dp_cmd.rd_load)
        begin
            status_reg <= rd_status;
            ok_reg     <= (rd_status == ST_OK);
        end
        else if (dp_cmd.finish)
        begin
            status_reg <= ST_OK;
            ok_reg     <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg         <= '0;
            table_ready_reg <= 1'b0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            pend_reg <= dp_cmd.neg_rd;
            if (cfg_we)
            begin
                len_reg         <= len_next;
                table_ready_reg <= 1'b0;
            end
            else if (dp_cmd.finish)
            begin
                table_ready_reg <= 1'b1;
            end
        end
    end

    assign status   = status_reg;
    assign mu_value = ok_reg ? mu_rd_reg : '0;

endmodule

// ===== sv/moebius_sieve_table.sv =====
// top level of the moebius sieve table
// A read request (cmd 1) returns its entry the cycle after it is taken, one read per
// cycle while out_stall is low. A compute request (cmd 0) sieves the first sieve_length
// entries (saturated to MAX_LENGTH) and answers when the table is complete; it runs an
// init pass, then scans each index and, for each unmarked prime p, negates its multiples
// and clears the multiples of p^2, all through the single write port of the table
// memory. Reads give status 2 until a compute follows reset or a length write, status 1
// for an index at or above the length.
module moebius_sieve_table #(
    parameter int MAX_LENGTH = ms_pkg::MAX_LENGTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ms_pkg::CFG_W-1:0]        sieve_length,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [ms_pkg::IDX_W-1:0]        read_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [ms_pkg::MU_W-1:0]  mu_value,
    output logic [ms_pkg::ST_W-1:0]         status
);
    import ms_pkg::*;

    ms_cmd_t  dp_cmd;
    ms_stat_t stat;

    assign cfg_ready = 1'b1;

    ms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_stall (out_stall),
        .stat      (stat),
        .dp_cmd    (dp_cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    ms_dpath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (sieve_length),
        .read_index (read_index),
        .dp_cmd     (dp_cmd),
        .stat       (stat),
        .mu_value   (mu_value),
        .status     (status)
    );

    a_sieve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd == CMD_SIEVE) |=> (in_stall && !out_valid))
        else $error("sieve request did not hold off the next request");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd == CMD_READ) |=> out_valid)
        else $error("read result missing one cycle after the request");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (mu_value == '0))
        else $error("nonzero value with error status");

    a_mu_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mu_value != 2'b10))
        else $error("value outside minus one to one");

endmodule
